FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while rst_n is low.
`define SWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define SWA_ASSERT_ALWAYS(label, cond, msg) \
  `SWA_ASSERT(label, (1'b1 |-> (cond)), msg)

`endif

FILE: hw/rtl/swa_pkg.sv
// Shared types and constants of the sliding window average block.
`timescale 1ns / 1ps

package swa_pkg;

  // Width of the window size register.
  localparam int CFG_W = 7;

  // Window size after reset.
  localparam logic [CFG_W-1:0] WIN_RESET = 7'd8;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;     // window size write: clear window, load new size
    logic capture;   // take the input sample, start read of oldest entry
    logic update;    // store sample, update sum, count and ring pointers
    logic div_load;  // load divider with |sum| and count
    logic div_step;  // one restoring division step
    logic load_out;  // move result into output register
  } swa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_last;  // current division step is the final one
  } swa_sts_t;

endpackage

FILE: hw/rtl/swa_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/swa_ctrl.sv
// Sequencing state machine of the sliding window average block.
`timescale 1ns / 1ps

module swa_ctrl
  import swa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  swa_sts_t sts,
  output swa_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_LOAD   = 5'b00100,
    S_DIV    = 5'b01000,
    S_OUT    = 5'b10000
  } swa_state_t;

  swa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.clear    = cfg_valid;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/swa_datapath.sv
// Ring store, running sum and serial divider of the sliding window average.
`timescale 1ns / 1ps

module swa_datapath
  import swa_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swa_cmd_t                      cmd,
  output swa_sts_t                      sts,
  input  logic [CFG_W-1:0]              cfg_window_size,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [CNT_W-1:0]              out_samples_in_window
);

  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int STEP_W = $clog2(SUM_W);

  function automatic logic [CNT_W-1:0] clamp_win(input logic [CFG_W-1:0] w);
    logic [CNT_W-1:0] r;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (int'(w) > MAX_WINDOW) begin
      r = CNT_W'(MAX_WINDOW);
    end else begin
      r = CNT_W'(w);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(MAX_WINDOW - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

  // window state
  logic [CNT_W-1:0]        win_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [IDX_W-1:0]        oldest_r, oldest_nxt;
  logic [IDX_W-1:0]        wr_idx_r, wr_idx_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                    full;

  // ring store
  logic [SAMPLE_BITS-1:0]  old_raw;
  logic signed [SUM_W-1:0] old_ext, new_ext;

  // divider
  logic [SUM_W-1:0]        quo_r;
  logic [CNT_W-1:0]        rem_r;
  logic [CNT_W-1:0]        dvsr_r;
  logic                    neg_r;
  logic [STEP_W-1:0]       step_r;
  logic [CNT_W:0]          trial;
  logic                    fits;
  logic [SUM_W-1:0]        signed_quo;

  // output register
  logic signed [SAMPLE_BITS-1:0] avg_r;
  logic [CNT_W-1:0]              cnt_out_r;

  assign full = (count_r >= win_r);

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .we      (cmd.update),
    .waddr   (wr_idx_r),
    .wdata   (sample_r),
    .re      (cmd.capture),
    .raddr   (oldest_r),
    .rdata_r (old_raw)
  );

  assign old_ext = SUM_W'($signed(old_raw));
  assign new_ext = SUM_W'(sample_r);

  always_comb begin
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    wr_idx_nxt = wr_idx_r;
    if (cmd.update) begin
      wr_idx_nxt = inc_idx(wr_idx_r);
      if (full) begin
        // oldest sample leaves, count stays
        sum_nxt    = sum_r + new_ext - old_ext;
        oldest_nxt = inc_idx(oldest_r);
      end else begin
        sum_nxt   = sum_r + new_ext;
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= clamp_win(WIN_RESET);
      count_r  <= '0;
      sum_r    <= '0;
      oldest_r <= '0;
      wr_idx_r <= '0;
    end else if (cmd.clear) begin
      win_r    <= clamp_win(cfg_window_size);
      count_r  <= '0;
      sum_r    <= '0;
      oldest_r <= '0;
      wr_idx_r <= '0;
    end else begin
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      oldest_r <= oldest_nxt;
      wr_idx_r <= wr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
  end

  // restoring division on magnitudes, one quotient bit per step
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvsr_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r  <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      neg_r  <= sum_r[SUM_W-1];
      rem_r  <= '0;
      dvsr_r <= count_r;
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= fits ? CNT_W'(trial - {1'b0, dvsr_r}) : CNT_W'(trial);
      quo_r  <= {quo_r[SUM_W-2:0], fits};
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign sts.div_last = (step_r == STEP_W'(SUM_W - 1));

  assign signed_quo = neg_r ? (~quo_r + SUM_W'(1)) : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      avg_r     <= signed_quo[SAMPLE_BITS-1:0];
      cnt_out_r <= count_r;
    end
  end

  assign out_average           = avg_r;
  assign out_samples_in_window = cnt_out_r;

endmodule

FILE: hw/rtl/sliding_window_average_top.sv
// Top level of the sliding window average block.
`timescale 1ns / 1ps

// Simple moving average of signed Q8.8 temperature samples. Each input
// transaction carries one sample; it goes into a ring store of the most
// recent window_size samples and into a running sum, and every input
// transaction yields exactly one output transaction: the mean of the stored
// samples (signed quotient, truncated toward zero) and the number of samples
// it was taken over. Once the window is full the oldest sample drops out.
// Steps per transaction: accept, store/sum update, divider load, one
// quotient bit per cycle of the restoring divider over SUM_W = SAMPLE_BITS +
// clog2(MAX_WINDOW) bits, hand-over to the output register, which waits
// for out_ready while an earlier result is still held there.
// The result sits in an output register, so the next input transaction is
// taken while an earlier result still waits for out_ready. A window size
// write (always accepted, cfg_ready tied high) clears the window; values of
// 0 act as 1 and values above MAX_WINDOW as MAX_WINDOW. Write it only while
// the block is idle. The sample store needs no clearing after reset.

module sliding_window_average_top
  import swa_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_average,
  output logic [$clog2(MAX_WINDOW + 1)-1:0]    out_samples_in_window,
  // window size register
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_W-1:0]                     cfg_window_size
);

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  swa_cmd_t cmd;
  swa_sts_t sts;

  // sequencer: handshakes and step order
  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring store, running sum, divider and output register
  swa_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_window_size       (cfg_window_size),
    .in_sample             (in_sample),
    .out_average           (out_average),
    .out_samples_in_window (out_samples_in_window)
  );

  // one transaction in flight: no second accept straight after the first
  `SWA_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "accept while busy")
  // a result never overwrites one that is still waiting
  `SWA_ASSERT_ALWAYS(a_no_overwrite, (!cmd.load_out || !out_valid || out_ready), "result lost")
  // a result only appears after the controller hands one over
  `SWA_ASSERT(a_out_from_load, $rose(out_valid) |-> $past(cmd.load_out), "spurious result")
  // an offered result always covers at least one sample
  `SWA_ASSERT_ALWAYS(a_count_nonzero, (!out_valid || out_samples_in_window != '0), "empty window")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the sliding window average block.
`timescale 1ns / 1ps

// Stimulus starts with a short table of samples and window size writes. Rows
// whose result is obvious carry the expected mean and count. All other rows,
// and the random phases after them, are checked against a local model of the
// ring store, the running sum and the signed division.
//
// Checking is done at the clock edge. A monitor watches every handshake. An
// accepted input transaction advances the model and queues one expected
// result. An accepted output transaction is compared with the oldest entry in
// that queue. Mismatches go through report_mismatch, and the run carries on.
//
// The sender offers samples in bursts of random length. The gaps between
// bursts are random, and some phases have no gaps at all. The receiver picks
// a stall pattern for a random span of cycles. Each window size write waits
// until every expected result has been collected. One phase holds out_ready
// low long enough for the block to fill up and drop in_ready. Another phase
// stops in the middle until the result queue is empty.
module testbench
  import swa_pkg::*;
();

  localparam int WINDOW_CAP     = 64;      // MAX_WINDOW of the instance
  localparam int ITEMS_TOTAL    = 1100;    // rough stop point for stimulus
  localparam int HOLD_CYCLES    = 400;     // long receiver hold-off
  localparam int TAIL_CYCLES    = 60;      // catches strays
  localparam int WATCHDOG_LIMIT = 4000;    // cycles without any handshake
  localparam int DIR_ROWS       = 30;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
  typedef enum {MIX_UNIFORM, MIX_TOP, MIX_BOTTOM, MIX_NEAR_ZERO, MIX_EDGES} sample_mix_t;
  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_mode_t;

  typedef struct packed {
    logic signed [15:0] avg;
    logic [6:0]         cnt;
  } window_mean_t;

  // Pending input transaction: typed-in expectation if the row has one.
  typedef struct packed {
    logic               typed;
    logic signed [15:0] avg;
    logic [6:0]         cnt;
  } sample_note_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        typed;
    logic [15:0] avg;
    logic [6:0]  cnt;
  } stim_row_t;

  // Directed rows. Window writes carry the size in value.
  stim_row_t dir_rows [DIR_ROWS] = '{
    // reset window of 8: plain mean, then a mean that cancels to zero
    '{ROW_SAMPLE, 16'h0100, 1'b1, 16'h0100, 7'd1},
    '{ROW_SAMPLE, 16'hFF00, 1'b1, 16'h0000, 7'd2},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 7'd0},
    // window of 1 passes samples straight through, extremes included
    '{ROW_WINDOW, 16'd1,    1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF, 7'd1},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000, 7'd1},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'hFFFF, 7'd1},
    // size zero behaves as a window of one
    '{ROW_WINDOW, 16'd0,    1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'h0005, 1'b1, 16'h0005, 7'd1},
    '{ROW_SAMPLE, 16'hFFF9, 1'b1, 16'hFFF9, 7'd1},
    // window of 2: -3/2 truncates to -1, then the oldest sample drops out
    '{ROW_WINDOW, 16'd2,    1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'hFFFD, 1'b1, 16'hFFFD, 7'd1},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'hFFFF, 7'd2},
    '{ROW_SAMPLE, 16'h0003, 1'b1, 16'h0001, 7'd2},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'h0000, 7'd0},
    // top value of the register is clamped to 64
    '{ROW_WINDOW, 16'd127,  1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000, 7'd1},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000, 7'd2},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 7'd0},
    // one above the cap; -1/2 truncates to zero
    '{ROW_WINDOW, 16'd65,   1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'h0064, 1'b1, 16'h0064, 7'd1},
    '{ROW_SAMPLE, 16'hFF9B, 1'b1, 16'h0000, 7'd2},
    // window of 3, wrapped once
    '{ROW_WINDOW, 16'd3,    1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'h0007, 1'b1, 16'h0007, 7'd1},
    '{ROW_SAMPLE, 16'h0008, 1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'h0009, 1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'h0000, 7'd0},
    // exactly the cap
    '{ROW_WINDOW, 16'd64,   1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 16'h0000, 7'd0},
    '{ROW_SAMPLE, 16'hAAAA, 1'b0, 16'h0000, 7'd0}
  };

  // DUT ports; every input known from time zero
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [15:0]       in_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [15:0]       out_average;
  logic [6:0]               out_samples_in_window;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_window_size = '0;

  // Local model of the window: ring store, pointers, count, sum, setting
  logic signed [15:0] ring_mem [WINDOW_CAP];
  logic [5:0]         oldest_slot = '0;
  logic [5:0]         next_slot = '0;
  logic [6:0]         fill_count = '0;
  logic signed [21:0] window_total = '0;
  logic [CFG_W-1:0]   window_setting = WIN_RESET;

  window_mean_t mean_q [$];      // expected results, oldest first
  sample_note_t note_q [$];      // offered but not yet accepted samples

  int  mismatches = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  window_writes = 0;
  int  holds_done = 0;
  int  idle_cycles = 0;
  bit  hold_request = 1'b0;

  sliding_window_average_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sample             (in_sample),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_average           (out_average),
    .out_samples_in_window (out_samples_in_window),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_window_size       (cfg_window_size)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // A window size write clears the window. The store contents do not matter,
  // because slots are only read after they have been refilled.
  function automatic void load_window(input logic [CFG_W-1:0] size);
    window_setting = size;
    oldest_slot    = '0;
    next_slot      = '0;
    fill_count     = '0;
    window_total   = '0;
  endfunction

  // One sample in, one mean out. Zero acts as 1 and the size is capped at 64.
  // Division truncates toward zero.
  function automatic window_mean_t push_sample(input logic signed [15:0] s);
    window_mean_t r;
    int           span;
    int           quot;
    span = (window_setting == 0) ? 1 :
           (window_setting > WINDOW_CAP) ? WINDOW_CAP : int'(window_setting);
    if (int'(fill_count) >= span) begin
      window_total = window_total - ring_mem[oldest_slot];
      oldest_slot  = oldest_slot + 6'd1;
      fill_count   = fill_count - 7'd1;
    end
    ring_mem[next_slot] = s;
    next_slot    = next_slot + 6'd1;
    window_total = window_total + s;
    fill_count   = fill_count + 7'd1;
    quot  = int'(window_total) / int'(fill_count);
    r.avg = quot[15:0];
    r.cnt = fill_count;
    return r;
  endfunction

  // Handshake monitor. It reads values from before the edge, since every
  // signal changes through nonblocking updates.
  always @(posedge clk) begin : monitor
    window_mean_t got;
    window_mean_t want;
    sample_note_t note;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        load_window(cfg_window_size);
        window_writes++;
      end
      // Compare results first. A result never belongs to a sample accepted
      // at the same edge.
      if (out_valid && out_ready) begin
        results_seen++;
        got.avg = out_average;
        got.cnt = out_samples_in_window;
        if (mean_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: average %0d count %0d",
                                    got.avg, got.cnt));
        end else begin
          want = mean_q.pop_front();
          if (got.avg !== want.avg)
            report_mismatch($sformatf("average %0d, expected %0d (result %0d)",
                                      got.avg, want.avg, results_seen));
          if (got.cnt !== want.cnt)
            report_mismatch($sformatf("count %0d, expected %0d (result %0d)",
                                      got.cnt, want.cnt, results_seen));
        end
      end
      if (in_valid && in_ready) begin
        note = (note_q.size() != 0) ? note_q.pop_front() : '0;
        want = push_sample(in_sample);
        if (note.typed) begin
          want.avg = note.avg;
          want.cnt = note.cnt;
        end
        mean_q.push_back(want);
      end
    end
  end

  // Watchdog: counts cycles in which no transaction is accepted on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: a random stall pattern for a random span of cycles. On request
  // it also holds out_ready low for HOLD_CYCLES.
  initial begin : receiver
    ready_mode_t mode;
    int          span;
    int          n;
    forever begin
      mode = ready_mode_t'($urandom_range(0, 2));
      span = $urandom_range(8, 64);
      for (n = 0; n < span; n++) begin
        if (hold_request) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
          holds_done++;
        end
        case (mode)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
          default:      out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Called at a rising edge. Returns at the edge where the sample is taken.
  // in_valid stays high, so the next offer may follow at once.
  task automatic offer_sample(input logic [15:0] value, input logic typed,
                              input logic [15:0] avg, input logic [6:0] cnt);
    note_q.push_back('{typed: typed, avg: avg, cnt: cnt});
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop in_valid and wait until every expected result has been collected.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (mean_q.size() != 0 || note_q.size() != 0);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] size);
    drain_results();
    cfg_valid       <= 1'b1;
    cfg_window_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample(input sample_mix_t mix);
    int v;
    case (mix)
      MIX_TOP:       v = ($urandom_range(0, 3) != 0) ? 32767 : int'($urandom_range(0, 65535));
      MIX_BOTTOM:    v = ($urandom_range(0, 3) != 0) ? -32768 : int'($urandom_range(0, 65535));
      MIX_NEAR_ZERO: v = int'($urandom_range(0, 16)) - 8;
      MIX_EDGES: begin
        case ($urandom_range(0, 4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = -1;
          3:       v = 1;
          default: v = 0;
        endcase
      end
      default:       v = int'($urandom_range(0, 65535));
    endcase
    return v[15:0];
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0] plan [9];
    logic [CFG_W-1:0] size;
    sample_mix_t      mix;
    int               phase;
    int               phase_len;
    int               burst_left;
    int               k;
    bit               no_gaps;

    // The first random phases go through the register edges, then random.
    plan = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd65, 7'd8, 7'd63, 7'd3};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].kind == ROW_WINDOW)
        write_window(dir_rows[k].value[CFG_W-1:0]);
      else
        offer_sample(dir_rows[k].value, dir_rows[k].typed, dir_rows[k].avg,
                     dir_rows[k].cnt);
    end

    // Random phases
    phase      = 0;
    burst_left = 1;
    while (samples_sent < ITEMS_TOTAL) begin
      size      = (phase < 9) ? plan[phase] : CFG_W'($urandom_range(0, 127));
      phase_len = $urandom_range(20, 110);
      mix       = sample_mix_t'($urandom_range(0, 4));
      // Full windows of 64 at both extremes give the largest sums.
      if (phase == 0) begin
        mix       = MIX_TOP;
        phase_len = 130;
      end else if (phase == 2) begin
        mix       = MIX_BOTTOM;
        phase_len = 130;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      write_window(size);
      // Long output stall so the block backs up into in_ready.
      if (phase == 1 || $urandom_range(0, 9) == 0)
        hold_request = 1'b1;
      for (k = 0; k < phase_len; k++) begin
        // Mid-phase pause until the block has emptied.
        if (k == phase_len / 2 && (phase == 3 || $urandom_range(0, 7) == 0))
          drain_results();
        offer_sample(pick_sample(mix), 1'b0, '0, '0);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (!no_gaps && $urandom_range(0, 2) != 0)
            idle_sender($urandom_range(1, 30));
        end
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    while (mean_q.size() != 0) begin
      void'(mean_q.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("Summary: %0d samples, %0d results checked, %0d window size writes",
             samples_sent, results_seen, window_writes);
    $display("  sizes 0, 1, 2, 63, 64, 65 and 127 among them; %0d long output stalls",
             holds_done);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
